/* rtl/core/llc_slice_hash_finder_macros.svh */
// Assertion macros for the LLC slice hash finder RTL.
`ifndef LLC_SLICE_HASH_FINDER_MACROS_SVH
`define LLC_SLICE_HASH_FINDER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LLCSH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llcsh assertion failed");
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LLCSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llcsh assertion failed");
`else
`define LLCSH_ASSERT_NOW(label, ante, cons)
`define LLCSH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/llcsh_pkg.sv */
// Types and constants shared by the LLC slice hash finder modules.
package llcsh_pkg;

    localparam int ADDR_WIDTH  = 48;
    localparam int LINE_BYTES  = 64;

    localparam int PHYS_W      = 48;
    localparam int MASK_W      = 48;
    localparam int LIMIT_W     = 16;
    localparam int OFF_W       = 22;
    localparam int SLICE_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;
    localparam int ADDR_VIEW_W = (ADDR_WIDTH > MASK_W) ? ADDR_WIDTH : MASK_W;

    localparam logic [MASK_W-1:0]  MASK0_RESET = 48'h001B_5F57_5440;
    localparam logic [MASK_W-1:0]  MASK1_RESET = 48'h002E_B5FA_A880;
    localparam logic [MASK_W-1:0]  MASK2_RESET = 48'h003C_CCC9_3100;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HASH_MASK0 = 2'd0,
        CFG_HASH_MASK1 = 2'd1,
        CFG_HASH_MASK2 = 2'd2,
        CFG_LIMIT      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [MASK_W-1:0]  hash_mask_bit0;
        logic [MASK_W-1:0]  hash_mask_bit1;
        logic [MASK_W-1:0]  hash_mask_bit2;
        logic [LIMIT_W-1:0] search_limit_lines;
    } cfg_regs_t;

    typedef struct packed {
        logic [PHYS_W-1:0]  phys_address;
        logic [SLICE_W-1:0] wanted_slice;
    } in_item_t;

    typedef struct packed {
        logic [SLICE_W-1:0] start_slice;
        logic [OFF_W-1:0]   byte_offset;
        logic               found;
    } res_item_t;

endpackage

/* rtl/core/llc_slice_hash_finder.sv */
// Top level of the LLC slice hash finder.
// The block takes a physical byte address and a wanted slice, reports the
// slice of that address, and searches forward one cache line at a time for
// the first line that maps to the wanted slice. A transaction is accepted
// when start is high and busy is low. The result appears on result for
// exactly one cycle with result_valid high; the receiver cannot stall it, so
// it must capture the result in that cycle. busy stays high while the line
// scan runs; a search that gives up ends the scan on the limit check, and
// with a search limit of zero that check is the whole scan. result_valid is
// high in the first cycle in which busy is low again, and that same cycle can
// already accept the next transaction. The search is paced by the single
// hash unit, which evaluates one line per cycle under the search sequencer.
// Configuration writes are always ready and must only be issued while the
// block is idle.
module llc_slice_hash_finder
    import llcsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Query transaction.
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    // Result strobe.
    output res_item_t             result,
    output logic                  result_valid,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_regs_t             regs;
    logic [ADDR_WIDTH-1:0] hash_addr;
    logic [SLICE_W-1:0]    hash_slice;

    // Hash masks and the search limit live here.
    llcsh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    // The one hash unit, shared by every line of the search.
    llcsh_hash u_hash (
        .addr  (hash_addr),
        .regs  (regs),
        .slice (hash_slice)
    );

    // The sequencer steps the address and counts the examined lines.
    llcsh_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .limit        (regs.search_limit_lines),
        .hash_addr    (hash_addr),
        .hash_slice   (hash_slice),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

/* rtl/core/llcsh_cfg.sv */
// Configuration register file for the LLC slice hash finder.
module llcsh_cfg
    import llcsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_regs_t             regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HASH_MASK0: regs_next.hash_mask_bit0 = cfg_data[MASK_W-1:0];
                CFG_HASH_MASK1: regs_next.hash_mask_bit1 = cfg_data[MASK_W-1:0];
                CFG_HASH_MASK2: regs_next.hash_mask_bit2 = cfg_data[MASK_W-1:0];
                CFG_LIMIT:      regs_next.search_limit_lines = cfg_data[LIMIT_W-1:0];
                default:        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.hash_mask_bit0     <= MASK0_RESET;
            regs_reg.hash_mask_bit1     <= MASK1_RESET;
            regs_reg.hash_mask_bit2     <= MASK2_RESET;
            regs_reg.search_limit_lines <= LIMIT_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

/* rtl/core/llcsh_hash.sv */
// Slice hash unit: three masked parities of one address.
module llcsh_hash
    import llcsh_pkg::*;
(
    input  logic [ADDR_WIDTH-1:0] addr,
    input  cfg_regs_t             regs,
    output logic [SLICE_W-1:0]    slice
);

    logic [ADDR_VIEW_W-1:0] addr_wide;
    logic [MASK_W-1:0]      addr_view;

    // Address bits above the mask width never take part in the hash.
    assign addr_wide = ADDR_VIEW_W'(addr);
    assign addr_view = addr_wide[MASK_W-1:0];

    assign slice[0] = ^(addr_view & regs.hash_mask_bit0);
    assign slice[1] = ^(addr_view & regs.hash_mask_bit1);
    assign slice[2] = ^(addr_view & regs.hash_mask_bit2);

endmodule

/* rtl/core/llcsh_seq.sv */
// Search sequencer: walks line by line through the shared hash unit.
`include "llc_slice_hash_finder_macros.svh"
module llcsh_seq
    import llcsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    input  logic [LIMIT_W-1:0]    limit,
    output logic [ADDR_WIDTH-1:0] hash_addr,
    input  logic [SLICE_W-1:0]    hash_slice,
    output res_item_t             result,
    output logic                  result_valid
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                state_reg,   state_next;
    logic [ADDR_WIDTH-1:0] addr_reg,    addr_next;
    logic [OFF_W-1:0]      off_reg,     off_next;
    logic [LIMIT_W-1:0]    cnt_reg,     cnt_next;
    logic [SLICE_W-1:0]    wanted_reg,  wanted_next;
    logic [SLICE_W-1:0]    sslice_reg,  sslice_next;
    res_item_t             result_reg,  result_next;
    logic                  rvalid_reg,  rvalid_next;

    logic [ADDR_VIEW_W-1:0] base_wide;
    logic [SLICE_W-1:0]     cur_start;
    logic                   accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign base_wide = ADDR_VIEW_W'(item.phys_address);
    // The first examined line is the start address itself.
    assign cur_start = (cnt_reg == '0) ? hash_slice : sslice_reg;

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        off_next    = off_reg;
        cnt_next    = cnt_reg;
        wanted_next = wanted_reg;
        sslice_next = sslice_reg;
        result_next = result_reg;
        rvalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    addr_next   = base_wide[ADDR_WIDTH-1:0];
                    wanted_next = item.wanted_slice;
                    off_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                sslice_next = cur_start;
                if (cnt_reg == limit)
                begin
                    result_next.start_slice = cur_start;
                    result_next.byte_offset = '0;
                    result_next.found       = 1'b0;
                    rvalid_next             = 1'b1;
                    state_next              = ST_IDLE;
                end
                else if (hash_slice == wanted_reg)
                begin
                    result_next.start_slice = cur_start;
                    result_next.byte_offset = off_reg;
                    result_next.found       = 1'b1;
                    rvalid_next             = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_WIDTH'(LINE_BYTES);
                    off_next  = off_reg + OFF_W'(LINE_BYTES);
                    cnt_next  = cnt_reg + LIMIT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            addr_reg   <= '0;
            off_reg    <= '0;
            cnt_reg    <= '0;
            wanted_reg <= '0;
            sslice_reg <= '0;
            result_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            off_reg    <= off_next;
            cnt_reg    <= cnt_next;
            wanted_reg <= wanted_next;
            sslice_reg <= sslice_next;
            result_reg <= result_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign hash_addr    = addr_reg;
    assign result       = result_reg;
    assign result_valid = rvalid_reg;

    // A result strobe comes only while the sequencer is idle, in the cycle after the scan ends.
    `LLCSH_ASSERT_NOW(a_strobe_when_idle, rvalid_reg, state_reg == ST_IDLE)
    // An accepted transaction starts its scan at line zero.
    `LLCSH_ASSERT_NEXT(a_accept_starts_scan, accept, (state_reg == ST_SCAN) && (cnt_reg == '0))
    // The line counter never runs past the search limit.
    `LLCSH_ASSERT_NOW(a_cnt_in_limit, state_reg == ST_SCAN, cnt_reg <= limit)
    // A miss reports a zero offset.
    `LLCSH_ASSERT_NOW(a_miss_zero_off, rvalid_reg && !result_reg.found, result_reg.byte_offset == '0)

endmodule
